### design/sac_pkg.sv
// ============================================================================
// Steering angle calibration package
// Fixed-point formats, limits and the two calibration tables with their
// precomputed Q16 segment slopes.
// ============================================================================
`default_nettype none

package sac_pkg;

    // Number of breakpoints in each table and segments between them.
    localparam int TABLE_POINTS = 25;
    localparam int SEGMENTS     = TABLE_POINTS - 1;
    localparam int NUM_TABLES   = 2;

    // Field widths.
    localparam int REQ_W     = 16;   // requested angle
    localparam int OFFSET_W  = 13;   // mounting offset register
    localparam int CDEG_W    = 15;   // calibrated angle and table entries
    localparam int SUM_W     = 17;   // requested angle plus offset
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = OFFSET_W;

    // Slope format: unsigned, SLOPE_FRAC_BITS fraction bits.
    localparam int SLOPE_FRAC_BITS = 16;
    localparam int SLOPE_W         = 19;
    // Offset into a segment stays below the widest segment width (6012).
    localparam int DELTA_W         = 13;
    localparam int PROD_W          = DELTA_W + SLOPE_W;
    localparam int STEP_W          = PROD_W - SLOPE_FRAC_BITS;
    localparam int RESULT_W        = 18;

    typedef logic signed [CDEG_W-1:0]  cdeg_t;
    typedef logic        [SLOPE_W-1:0] slope_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SELECT = 1'd1;

    // Plus or minus 90 degrees in centidegrees.
    localparam cdeg_t LIMIT_POS = 15'sd9000;
    localparam cdeg_t LIMIT_NEG = -15'sd9000;

    // Round-half-up constant for the slope product.
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SLOPE_FRAC_BITS - 1);

    // Set-point table shared by both units.
    localparam cdeg_t SET_PTS [TABLE_POINTS] = '{
        -15'sd9000, -15'sd3000, -15'sd2500, -15'sd2300, -15'sd2000,
        -15'sd1500, -15'sd1000, -15'sd800,  -15'sd500,  -15'sd300,
        -15'sd200,  -15'sd100,  15'sd0,     15'sd100,   15'sd200,
        15'sd300,   15'sd500,   15'sd800,   15'sd1000,  15'sd1500,
        15'sd2000,  15'sd2300,  15'sd2500,  15'sd3000,  15'sd9000
    };

    // Measured feedback breakpoints, one row per unit.
    localparam cdeg_t FB_PTS [NUM_TABLES][TABLE_POINTS] = '{
        '{
            -15'sd9000, -15'sd3010, -15'sd2494, -15'sd2279, -15'sd1958,
            -15'sd1422, -15'sd888,  -15'sd672,  -15'sd350,  -15'sd136,
            -15'sd28,   -15'sd8,    -15'sd8,    -15'sd8,    15'sd12,
            15'sd118,   15'sd334,   15'sd656,   15'sd872,   15'sd1406,
            15'sd1942,  15'sd2264,  15'sd2478,  15'sd2988,  15'sd9000
        },
        '{
            -15'sd9000, -15'sd2996, -15'sd2512, -15'sd2310, -15'sd2010,
            -15'sd1510, -15'sd1010, -15'sd810,  -15'sd510,  -15'sd310,
            -15'sd210,  -15'sd114,  -15'sd8,    15'sd86,    15'sd190,
            15'sd286,   15'sd490,   15'sd790,   15'sd990,   15'sd1488,
            15'sd1992,  15'sd2294,  15'sd2488,  15'sd2988,  15'sd9000
        }
    };

    // Segment slopes (set delta over feedback delta, Q16, rounded half up).
    // Zero-width segments can never be selected and carry a zero slope.
    localparam slope_t SLOPES [NUM_TABLES][SEGMENTS] = '{
        '{
            19'd65645,  19'd63504,  19'd60964,  19'd61249,  19'd61134,
            19'd61363,  19'd60681,  19'd61058,  19'd61249,  19'd60681,
            19'd327680, 19'd0,      19'd0,      19'd327680, 19'd61826,
            19'd60681,  19'd61058,  19'd60681,  19'd61363,  19'd61134,
            19'd61058,  19'd61249,  19'd64251,  19'd65405
        },
        '{
            19'd65492,  19'd67702,  19'd64887,  19'd65536,  19'd65536,
            19'd65536,  19'd65536,  19'd65536,  19'd65536,  19'd65536,
            19'd68267,  19'd61826,  19'd69719,  19'd63015,  19'd68267,
            19'd64251,  19'd65536,  19'd65536,  19'd65799,  19'd65016,
            19'd65102,  19'd67563,  19'd65536,  19'd65405
        }
    };

endpackage

`default_nettype wire

### design/steer_angle_calibration_unit.sv
// ============================================================================
// Steering angle calibration unit
// Offset, clamp and piecewise linear calibration of a requested wheel angle.
// ============================================================================
//
// The unit takes one requested wheel angle per beat (centidegrees, positive to
// the left), adds the mounting offset and clamps the sum to plus or minus 9000.
// The clamped angle is located in the selected 25-point measured-feedback
// table and mapped linearly onto the set-point table with a Q16 slope, rounded
// to the nearest centidegree; angles at either end give exactly plus or minus
// 9000. Every input beat yields exactly one output beat. The unit accepts one
// beat per clock cycle while the output is not stalled: an input register
// feeds a single pass of compare, select and one 13 by 19 bit multiply-add
// into the output register, where the result is held until it is taken.
// Input is taken while a finished result is stalled, as long as the input
// register is free. The user must write configuration registers only while
// the unit is idle; the unit itself does not enforce this.
//
`default_nettype none

module steer_angle_calibration_unit
    import sac_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    // Configuration write port.
    input  wire logic                        cfg_write,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]            cfg_data,

    // Input channel.
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [REQ_W-1:0]     requested_angle,

    // Output channel.
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [CDEG_W-1:0]         commanded_angle,
    output logic                             was_clamped
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [OFFSET_W-1:0] angle_offset_reg;
    logic                       table_select_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_offset_reg <= '0;
            table_select_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ANGLE_OFFSET: angle_offset_reg <= cfg_data;
                REG_TABLE_SELECT: table_select_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The output register loads a held input beat whenever it is empty
    // or its own beat is being taken; the input register then hands its beat on.
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic in_load;

    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !out_load;
    assign in_load  = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input payload register.
    logic signed [REQ_W-1:0] angle_reg;

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            angle_reg <= requested_angle;
        end
    end

    // ------------------------------------------------------------------
    // Offset and clamp.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] sum;
    cdeg_t                   clamped_angle;
    logic                    clamped_next;

    assign sum = SUM_W'(angle_reg) + SUM_W'(angle_offset_reg);

    always_comb
    begin
        clamped_next  = 1'b0;
        clamped_angle = CDEG_W'(sum);
        if (sum < SUM_W'(LIMIT_NEG))
        begin
            clamped_angle = LIMIT_NEG;
            clamped_next  = 1'b1;
        end
        else if (sum > SUM_W'(LIMIT_POS))
        begin
            clamped_angle = LIMIT_POS;
            clamped_next  = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Segment search. Breakpoints are non-decreasing, so at most one
    // segment holds the angle and the matches can simply be ORed together.
    // A zero-width segment never matches.
    // ------------------------------------------------------------------
    cdeg_t  seg_fb;
    cdeg_t  seg_set;
    slope_t seg_slope;

    always_comb
    begin
        logic hit;
        seg_fb    = '0;
        seg_set   = '0;
        seg_slope = '0;
        for (int j = 0; j < SEGMENTS; j++)
        begin
            hit = (clamped_angle >= FB_PTS[table_select_reg][j]) &&
                  (clamped_angle <  FB_PTS[table_select_reg][j+1]);
            seg_fb    = seg_fb    | (hit ? FB_PTS[table_select_reg][j] : '0);
            seg_set   = seg_set   | (hit ? SET_PTS[j] : '0);
            seg_slope = seg_slope | (hit ? SLOPES[table_select_reg][j] : '0);
        end
    end

    // ------------------------------------------------------------------
    // Interpolation: set + round((angle - fb) * slope).
    // ------------------------------------------------------------------
    logic signed [CDEG_W:0]       delta_full;
    logic        [DELTA_W-1:0]    delta;
    logic        [PROD_W-1:0]     prod;
    logic        [PROD_W-1:0]     prod_rounded;
    logic        [STEP_W-1:0]     step;
    logic signed [RESULT_W-1:0]   interp;
    cdeg_t                        angle_next;

    assign delta_full   = (CDEG_W+1)'(clamped_angle) - (CDEG_W+1)'(seg_fb);
    assign delta        = delta_full[DELTA_W-1:0];
    assign prod         = PROD_W'(delta) * PROD_W'(seg_slope);
    assign prod_rounded = prod + ROUND_HALF;
    assign step         = prod_rounded[PROD_W-1:SLOPE_FRAC_BITS];
    assign interp       = RESULT_W'(seg_set) + RESULT_W'($unsigned(step));

    always_comb
    begin
        if (clamped_angle <= LIMIT_NEG)
        begin
            angle_next = LIMIT_NEG;
        end
        else if (clamped_angle >= LIMIT_POS)
        begin
            angle_next = LIMIT_POS;
        end
        else if (interp < RESULT_W'(LIMIT_NEG))
        begin
            angle_next = LIMIT_NEG;
        end
        else if (interp > RESULT_W'(LIMIT_POS))
        begin
            angle_next = LIMIT_POS;
        end
        else
        begin
            angle_next = CDEG_W'(interp);
        end
    end

    // ------------------------------------------------------------------
    // Output payload register.
    // ------------------------------------------------------------------
    cdeg_t commanded_reg;
    logic  clamped_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            commanded_reg <= angle_next;
            clamped_reg   <= clamped_next;
        end
    end

    assign commanded_angle = commanded_reg;
    assign was_clamped     = clamped_reg;

endmodule

`default_nettype wire
